@@ rtl/nalsplit_pkg.sv @@
`timescale 1ns / 1ps

package nalsplit_pkg;

	// Field types shared by the channel interfaces and the splitter
	typedef logic [7:0] byte_t;

	// Most result transfers one input byte can cause: one shifted out, four flushed
	localparam int MaxResults = 5;
	// Depth of the hold window that looks for a three-byte start code
	localparam int HeldDepth  = 4;
	// Length of the opening start code of a frame
	localparam int HeaderLen  = 4;

	// Opening start code 00 00 00 01
	localparam byte_t StartCode [HeaderLen] = '{8'h00, 8'h00, 8'h00, 8'h01};
	// Last byte of every start code
	localparam byte_t CodeOne   = 8'h01;
	localparam byte_t CodeZero  = 8'h00;

	// One result transfer
	typedef struct packed {
		byte_t out_byte;
		logic  byte_valid;
		logic  nal_end;
		logic  start_error;
	} result_t;

endpackage

@@ rtl/nalsplit_in_if.sv @@
`timescale 1ns / 1ps

// Input channel: one frame byte per transfer
interface nalsplit_in_if;
	logic                 valid;
	logic                 ready;
	nalsplit_pkg::byte_t  data_byte;
	logic                 frame_last;

	modport source (output valid, output data_byte, output frame_last, input ready);
	modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

@@ rtl/nalsplit_out_if.sv @@
`timescale 1ns / 1ps

// Output channel: one payload byte or error flag per transfer
interface nalsplit_out_if;
	logic                 valid;
	logic                 ready;
	nalsplit_pkg::byte_t  out_byte;
	logic                 byte_valid;
	logic                 nal_end;
	logic                 start_error;

	modport source (output valid, output out_byte, output byte_valid, output nal_end,
		output start_error, input ready);
	modport sink   (input valid, input out_byte, input byte_valid, input nal_end,
		input start_error, output ready);
endinterface

@@ rtl/annexb_nal_splitter_top.sv @@
`timescale 1ns / 1ps

// Annex B NAL splitter. Takes one encoded frame a byte per transfer, frame_last on its
// final byte. The frame must open with 00 00 00 01, else one start_error result is sent
// and the rest of the frame is dropped. After that, start codes are stripped, the byte
// before each 00 00 01 is dropped, and payload bytes come out in order with nal_end on
// each NAL's last byte; at frame end all held bytes are flushed. Results of a byte are
// registered and show in the cycle after its transfer. A byte that causes zero or one
// result is taken every cycle while the receiver is ready; a byte that causes more
// results (up to five on a frame's final byte) holds the input until the last is taken,
// since the single result buffer drains one result per cycle while the receiver is ready.
module annexb_nal_splitter_top (
	input  logic                  clk,
	input  logic                  arst_n,
	nalsplit_in_if.sink           in_ch,
	nalsplit_out_if.source        out_ch
);

	localparam int HeldW = $clog2(nalsplit_pkg::HeldDepth + 1);
	localparam int HposW = $clog2(nalsplit_pkg::HeaderLen + 1);
	localparam int ResW  = $clog2(nalsplit_pkg::MaxResults + 1);
	localparam int IdxW  = $clog2(nalsplit_pkg::MaxResults);
	localparam int HIdxW = $clog2(nalsplit_pkg::HeldDepth);

	// Frame parse state
	nalsplit_pkg::byte_t   held_q [nalsplit_pkg::HeldDepth];
	logic [HeldW-1:0]      held_cnt_q;
	logic [HposW-1:0]      hpos_q;
	logic                  failed_q;

	// Result buffer for the last accepted byte
	nalsplit_pkg::result_t res_s1 [nalsplit_pkg::MaxResults];
	logic [ResW-1:0]       res_cnt_s1;
	logic [IdxW-1:0]       rd_q;

	// Next-state and result signals
	nalsplit_pkg::byte_t   held_d [nalsplit_pkg::HeldDepth];
	logic [HeldW-1:0]      held_cnt_d;
	logic [HposW-1:0]      hpos_d;
	logic                  failed_d;
	nalsplit_pkg::result_t res_d [nalsplit_pkg::MaxResults];
	logic [ResW-1:0]       res_n;
	logic [HeldW-1:0]      cnt_m1;
	logic [HeldW-1:0]      cnt_m2;
	logic                  code_hit;

	logic                  in_fire;
	logic                  out_fire;
	logic                  last_out;

	nalsplit_pkg::byte_t   b;
	logic                  last;

	assign b    = in_ch.data_byte;
	assign last = in_ch.frame_last;

	assign cnt_m1   = held_cnt_q - HeldW'(1);
	assign cnt_m2   = held_cnt_q - HeldW'(2);
	assign code_hit = (held_cnt_q >= HeldW'(2)) && (b == nalsplit_pkg::CodeOne)
		&& (held_q[cnt_m2[HIdxW-1:0]] == nalsplit_pkg::CodeZero)
		&& (held_q[cnt_m1[HIdxW-1:0]] == nalsplit_pkg::CodeZero);

	// Parse one byte: next state and its list of results
	always_comb begin
		held_d     = held_q;
		held_cnt_d = held_cnt_q;
		hpos_d     = hpos_q;
		failed_d   = failed_q;
		res_n      = '0;
		for (int i = 0; i < nalsplit_pkg::MaxResults; i++) begin
			res_d[i] = '0;
		end

		if (failed_q) begin
			// rest of a bad frame is ignored; frame end restarts the opening check
			if (last) begin
				failed_d   = 1'b0;
				held_cnt_d = '0;
				hpos_d     = '0;
			end
		end else if (hpos_q < HposW'(nalsplit_pkg::HeaderLen)) begin
			// opening start code check
			if (b != nalsplit_pkg::StartCode[hpos_q[HIdxW-1:0]]) begin
				res_d[0].start_error = 1'b1;
				res_n = ResW'(1);
				if (last) begin
					held_cnt_d = '0;
					hpos_d     = '0;
				end else begin
					failed_d = 1'b1;
				end
			end else if (last) begin
				if (hpos_q + HposW'(1) < HposW'(nalsplit_pkg::HeaderLen)) begin
					res_d[0].start_error = 1'b1;
					res_n = ResW'(1);
				end
				held_cnt_d = '0;
				hpos_d     = '0;
			end else begin
				hpos_d = hpos_q + HposW'(1);
			end
		end else if (code_hit) begin
			// start code: emit what is left before the dropped byte
			if (held_cnt_q == HeldW'(nalsplit_pkg::HeldDepth)) begin
				res_d[0] = '{out_byte: held_q[0], byte_valid: 1'b1, nal_end: 1'b1,
					start_error: 1'b0};
				res_n = ResW'(1);
			end
			held_cnt_d = '0;
			if (last) begin
				hpos_d = '0;
			end
		end else begin
			// shift the window when full, then append the byte
			if (held_cnt_q == HeldW'(nalsplit_pkg::HeldDepth)) begin
				res_d[0] = '{out_byte: held_q[0], byte_valid: 1'b1, nal_end: 1'b0,
					start_error: 1'b0};
				res_n = ResW'(1);
				for (int i = 0; i < nalsplit_pkg::HeldDepth - 1; i++) begin
					held_d[i] = held_q[i+1];
				end
				held_d[nalsplit_pkg::HeldDepth-1] = b;
				held_cnt_d = HeldW'(nalsplit_pkg::HeldDepth);
			end else begin
				held_d[held_cnt_q[HIdxW-1:0]] = b;
				held_cnt_d = held_cnt_q + HeldW'(1);
			end
			// frame end: flush the window
			if (last) begin
				for (int i = 0; i < nalsplit_pkg::HeldDepth; i++) begin
					if (HeldW'(i) < held_cnt_d) begin
						res_d[IdxW'(res_n) + IdxW'(i)] = '{out_byte: held_d[i],
							byte_valid: 1'b1,
							nal_end: (HeldW'(i) == held_cnt_d - HeldW'(1)),
							start_error: 1'b0};
					end
				end
				res_n      = res_n + ResW'(held_cnt_d);
				held_cnt_d = '0;
				hpos_d     = '0;
			end
		end
	end

	// Handshake: take a byte once the buffer is empty or emptying this cycle
	assign last_out     = (ResW'(rd_q) == res_cnt_s1 - ResW'(1));
	assign out_fire     = out_ch.valid && out_ch.ready;
	assign in_ch.ready  = (res_cnt_s1 == '0) || (out_ch.ready && last_out);
	assign in_fire      = in_ch.valid && in_ch.ready;

	assign out_ch.valid       = (res_cnt_s1 != '0);
	assign out_ch.out_byte    = res_s1[rd_q].out_byte;
	assign out_ch.byte_valid  = res_s1[rd_q].byte_valid;
	assign out_ch.nal_end     = res_s1[rd_q].nal_end;
	assign out_ch.start_error = res_s1[rd_q].start_error;

	// Parse state and result buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= '0;
			hpos_q     <= '0;
			failed_q   <= 1'b0;
			res_cnt_s1 <= '0;
			rd_q       <= '0;
		end else begin
			if (in_fire) begin
				held_cnt_q <= held_cnt_d;
				hpos_q     <= hpos_d;
				failed_q   <= failed_d;
				res_cnt_s1 <= res_n;
				rd_q       <= '0;
			end else if (out_fire) begin
				if (last_out) begin
					res_cnt_s1 <= '0;
					rd_q       <= '0;
				end else begin
					rd_q <= rd_q + IdxW'(1);
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			held_q <= held_d;
			res_s1 <= res_d;
		end
	end

endmodule

@@ tb/sv/nal_split_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the splitter. It predicts the payload and error transfers
// of every accepted frame byte and compares each output transfer with the oldest
// prediction still waiting.
module nal_split_checker (
	input  logic      clk,
	input  logic      arst_n,
	nalsplit_in_if    in_ch,
	nalsplit_out_if   out_ch,
	output int        fail_count,
	output int        pending,
	output int        results_seen,
	output int        nal_ends_seen,
	output int        errors_seen
);

	// Predicted splitter state
	nalsplit_pkg::byte_t   held [nalsplit_pkg::HeldDepth];
	int                    held_cnt;
	int                    hdr_pos;
	logic                  frame_failed;

	// Predicted output transfers, oldest first
	nalsplit_pkg::result_t expected_results [$];

	function automatic void clear_frame();
		held_cnt     = 0;
		hdr_pos      = 0;
		frame_failed = 1'b0;
	endfunction

	function automatic void push_payload(nalsplit_pkg::byte_t b, logic last_of_nal);
		expected_results.push_back('{out_byte: b, byte_valid: 1'b1,
			nal_end: last_of_nal, start_error: 1'b0});
	endfunction

	function automatic void push_error();
		expected_results.push_back('{out_byte: nalsplit_pkg::CodeZero, byte_valid: 1'b0,
			nal_end: 1'b0, start_error: 1'b1});
	endfunction

	// Works out the transfers that one frame byte causes
	function automatic void split_byte(nalsplit_pkg::byte_t b, logic last);
		int keep;
		// Rest of a frame with a bad opening is dropped
		if (frame_failed) begin
			if (last)
				clear_frame();
			return;
		end
		// Opening start code
		if (hdr_pos < nalsplit_pkg::HeaderLen) begin
			if (b != nalsplit_pkg::StartCode[hdr_pos]) begin
				push_error();
				if (last)
					clear_frame();
				else
					frame_failed = 1'b1;
			end else begin
				hdr_pos++;
				if (last) begin
					// frame ended inside the opening code
					if (hdr_pos < nalsplit_pkg::HeaderLen)
						push_error();
					clear_frame();
				end
			end
			return;
		end
		// 00 00 01 closes the NAL; the byte in front of it is dropped
		if (held_cnt >= 2 && b == nalsplit_pkg::CodeOne &&
			held[held_cnt - 2] == nalsplit_pkg::CodeZero &&
			held[held_cnt - 1] == nalsplit_pkg::CodeZero) begin
			keep = held_cnt - 3;
			for (int i = 0; i < keep; i++)
				push_payload(held[i], i == keep - 1);
			held_cnt = 0;
			if (last)
				clear_frame();
			return;
		end
		// Window full: oldest byte is known to be payload
		if (held_cnt == nalsplit_pkg::HeldDepth) begin
			push_payload(held[0], 1'b0);
			for (int i = 0; i < nalsplit_pkg::HeldDepth - 1; i++)
				held[i] = held[i + 1];
			held_cnt = nalsplit_pkg::HeldDepth - 1;
		end
		held[held_cnt] = b;
		held_cnt++;
		// Frame end flushes the window
		if (last) begin
			for (int i = 0; i < held_cnt; i++)
				push_payload(held[i], i == held_cnt - 1);
			clear_frame();
		end
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Output transfers are checked before the same edge's input byte is predicted,
	// since a byte's results show no earlier than the next cycle.
	always @(posedge clk or negedge arst_n) begin
		nalsplit_pkg::result_t want;
		if (!arst_n) begin
			expected_results.delete();
			held = '{default: nalsplit_pkg::CodeZero};
			clear_frame();
			fail_count    = 0;
			results_seen  = 0;
			nal_ends_seen = 0;
			errors_seen   = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				if (out_ch.nal_end)
					nal_ends_seen++;
				if (out_ch.start_error)
					errors_seen++;
				if (expected_results.size() == 0) begin
					$error("result transfer 0x%0h/%b/%b/%b with nothing expected",
						out_ch.out_byte, out_ch.byte_valid, out_ch.nal_end,
						out_ch.start_error);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("out_byte", want.out_byte, out_ch.out_byte);
					check_field("byte_valid", want.byte_valid, out_ch.byte_valid);
					check_field("nal_end", want.nal_end, out_ch.nal_end);
					check_field("start_error", want.start_error, out_ch.start_error);
				end
			end
			if (in_ch.valid && in_ch.ready)
				split_byte(in_ch.data_byte, in_ch.frame_last);
		end
		pending = expected_results.size();
	end

endmodule

@@ tb/sv/annexb_nal_splitter_top_test.sv @@
`timescale 1ns / 1ps

module annexb_nal_splitter_top_test;

	logic clk;
	logic arst_n;

	nalsplit_in_if  in_ch ();
	nalsplit_out_if out_ch ();

	int fail_count;
	int pending;
	int results_seen;
	int nal_ends_seen;
	int errors_seen;

	int send_idle_pct;
	int recv_idle_pct;
	int n_bytes;
	int n_frames;
	logic leftover;

	annexb_nal_splitter_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	nal_split_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_ch         (in_ch),
		.out_ch        (out_ch),
		.fail_count    (fail_count),
		.pending       (pending),
		.results_seen  (results_seen),
		.nal_ends_seen (nal_ends_seen),
		.errors_seen   (errors_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver stalls at random
	always @(posedge clk) begin
		out_ch.ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	// Hard stop for a hung handshake
	initial begin
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

	// One byte transfer; called and returns at a rising edge
	task automatic send_byte(input nalsplit_pkg::byte_t b, input logic last);
		logic took;
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.data_byte  <= b;
		in_ch.frame_last <= last;
		// ready is stable from the falling edge to the next rising edge
		do begin
			@(negedge clk);
			took = in_ch.ready;
			@(posedge clk);
		end while (!took);
		n_bytes++;
	endtask

	task automatic send_frame(input nalsplit_pkg::byte_t frm [$]);
		foreach (frm[i])
			send_byte(frm[i], i == frm.size() - 1);
		n_frames++;
	endtask

	// Hold off the sender until every predicted result has come out
	task automatic drain();
		int waited;
		in_ch.valid <= 1'b0;
		waited = 0;
		do begin
			@(negedge clk);
			waited++;
		end while (pending != 0 && waited < 20000);
		if (pending != 0) begin
			$error("%0d predicted results never came out", pending);
			leftover = 1'b1;
		end
		// results trail the byte that caused them
		repeat (8) @(posedge clk);
	endtask

	// Mostly well-formed frames with start codes and zero runs in the payload,
	// the rest with a broken or cut-short opening
	task automatic send_random_frame();
		nalsplit_pkg::byte_t frm [$];
		int    kind;
		int    len;
		int    pos;
		kind = $urandom_range(99);
		frm  = {};
		if (kind < 82) begin
			foreach (nalsplit_pkg::StartCode[i])
				frm.push_back(nalsplit_pkg::StartCode[i]);
			len = $urandom_range(0, 14);
			while (frm.size() < nalsplit_pkg::HeaderLen + len) begin
				case ($urandom_range(9))
					0: frm = {frm, nalsplit_pkg::CodeZero, nalsplit_pkg::CodeZero,
						nalsplit_pkg::CodeOne};
					1: frm = {frm, nalsplit_pkg::CodeZero, nalsplit_pkg::CodeZero,
						nalsplit_pkg::CodeZero, nalsplit_pkg::CodeOne};
					2, 3: frm.push_back(nalsplit_pkg::CodeZero);
					4: frm.push_back(nalsplit_pkg::CodeOne);
					default: frm.push_back(nalsplit_pkg::byte_t'($urandom_range(255)));
				endcase
			end
		end else if (kind < 92) begin
			pos = $urandom_range(nalsplit_pkg::HeaderLen - 1);
			for (int i = 0; i < nalsplit_pkg::HeaderLen; i++)
				frm.push_back((i == pos)
					? nalsplit_pkg::StartCode[i] ^ nalsplit_pkg::byte_t'($urandom_range(1, 255))
					: nalsplit_pkg::StartCode[i]);
			len = $urandom_range(0, 5);
			for (int i = 0; i < len; i++)
				frm.push_back(nalsplit_pkg::byte_t'($urandom_range(255)));
		end else begin
			len = $urandom_range(1, nalsplit_pkg::HeaderLen - 1);
			for (int i = 0; i < len; i++)
				frm.push_back(nalsplit_pkg::StartCode[i]);
		end
		send_frame(frm);
	endtask

	initial begin
		nalsplit_pkg::byte_t frm [$];
		int    phase_start;
		in_ch.valid      <= 1'b0;
		in_ch.data_byte  <= nalsplit_pkg::CodeZero;
		in_ch.frame_last <= 1'b0;
		arst_n        = 1'b0;
		send_idle_pct = 12;
		recv_idle_pct = 49;
		n_bytes       = 0;
		n_frames      = 0;
		leftover      = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extreme bytes, dropped byte before a code, an empty NAL, flush at frame end
		frm = {8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01,
			8'h00, 8'h00, 8'h01, 8'h80, 8'h7F};
		send_frame(frm);
		// Bad opening byte; rest of frame ignored
		frm = {8'h80, 8'h55};
		send_frame(frm);
		// Frame shorter than the opening code
		frm = {8'h00, 8'h00};
		send_frame(frm);
		// Start code ending on the final byte
		frm = {8'h00, 8'h00, 8'h00, 8'h01, 8'h42, 8'h00, 8'h00, 8'h01};
		send_frame(frm);

		// Random frames under three idling patterns
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 12; recv_idle_pct = 49; end
				1: begin send_idle_pct = 49; recv_idle_pct = 12; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			phase_start = n_bytes;
			while (n_bytes - phase_start < 60)
				send_random_frame();
			drain();
		end

		$display("tb: %0d bytes in %0d frames, good, broken and cut-short openings",
			n_bytes, n_frames);
		$display("tb: %0d results checked, %0d NAL ends, %0d opening errors",
			results_seen, nal_ends_seen, errors_seen);
		if (fail_count == 0 && !leftover)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
